// ===== design/pce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg
// Types and fixed constants shared by the correlation engine modules.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int MUL_W  = 64;   // magnitude width of a long multiply operand
  localparam int OP_W   = 66;   // signed width of finish-phase operands
  localparam int PROD_W = 128;  // full product width
  localparam int QUO_W  = 33;   // quotient width of the ratio divide
  localparam int ROOT_W = 17;   // square root width
  localparam int CNT_W  = 6;

  localparam logic [2:0] OP_N_SXX  = 3'd0;
  localparam logic [2:0] OP_SX_SX  = 3'd1;
  localparam logic [2:0] OP_N_SYY  = 3'd2;
  localparam logic [2:0] OP_SY_SY  = 3'd3;
  localparam logic [2:0] OP_N_SXY  = 3'd4;
  localparam logic [2:0] OP_SX_SY  = 3'd5;
  localparam logic [2:0] OP_MAG_SQ = 3'd6;
  localparam logic [2:0] OP_DEN    = 3'd7;

  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd31;
  localparam logic [CNT_W-1:0] ROOT_TOP  = 6'd16;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic               degenerate;
    logic               too_many;
    logic [12:0]        item_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_STORE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_SQRT_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       acc_en;
    logic       mul_load;
    logic       mul_run;
    logic       mul_store;
    logic [2:0] mul_op;
    logic [1:0] mul_step;
    logic       div_init;
    logic       div_run;
    logic       sqrt_init;
    logic       sqrt_run;
    logic [4:0] root_bit;
    logic       emit;
  } cmd_t;

endpackage

// ===== design/pce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_ctrl
// Sequencer for word intake and the once-per-set finish computation.
// ----------------------------------------------------------------------------
module pce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last,
  output logic          busy,
  output pce_pkg::cmd_t cmd
);

  pce_pkg::state_t state, state_next;
  logic [2:0] op_idx, op_idx_next;
  logic [pce_pkg::CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pce_pkg::ST_IDLE;
      op_idx <= '0;
      cnt    <= '0;
    end else begin
      state  <= state_next;
      op_idx <= op_idx_next;
      cnt    <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_idx_next = op_idx;
    cnt_next    = cnt;
    case (state)
      pce_pkg::ST_IDLE: begin
        if (start && last) begin
          state_next  = pce_pkg::ST_MUL_LOAD;
          op_idx_next = '0;
        end
      end
      pce_pkg::ST_MUL_LOAD: begin
        state_next = pce_pkg::ST_MUL_RUN;
        cnt_next   = '0;
      end
      pce_pkg::ST_MUL_RUN: begin
        cnt_next = cnt + 1'b1;
        if (cnt[1:0] == 2'd3) state_next = pce_pkg::ST_MUL_STORE;
      end
      pce_pkg::ST_MUL_STORE: begin
        if (op_idx == pce_pkg::OP_DEN) begin
          state_next = pce_pkg::ST_DIV_INIT;
        end else begin
          state_next  = pce_pkg::ST_MUL_LOAD;
          op_idx_next = op_idx + 1'b1;
        end
      end
      pce_pkg::ST_DIV_INIT: begin
        state_next = pce_pkg::ST_DIV_RUN;
        cnt_next   = '0;
      end
      pce_pkg::ST_DIV_RUN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == pce_pkg::DIV_STEPS) begin
          state_next = pce_pkg::ST_SQRT_RUN;
          cnt_next   = pce_pkg::ROOT_TOP;
        end
      end
      pce_pkg::ST_SQRT_RUN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = pce_pkg::ST_DONE;
      end
      pce_pkg::ST_DONE: begin
        state_next = pce_pkg::ST_IDLE;
      end
      default: begin
        state_next = pce_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_op   = op_idx;
    cmd.mul_step = cnt[1:0];
    cmd.root_bit = cnt[4:0];
    busy         = (state != pce_pkg::ST_IDLE);
    case (state)
      pce_pkg::ST_IDLE:      cmd.acc_en = start;
      pce_pkg::ST_MUL_LOAD:  cmd.mul_load = 1'b1;
      pce_pkg::ST_MUL_RUN:   cmd.mul_run = 1'b1;
      pce_pkg::ST_MUL_STORE: cmd.mul_store = 1'b1;
      pce_pkg::ST_DIV_INIT:  cmd.div_init = 1'b1;
      pce_pkg::ST_DIV_RUN: begin
        cmd.div_run   = 1'b1;
        cmd.sqrt_init = (cnt == pce_pkg::DIV_STEPS);
      end
      pce_pkg::ST_SQRT_RUN:  cmd.sqrt_run = 1'b1;
      pce_pkg::ST_DONE:      cmd.emit = 1'b1;
      default:               cmd = '0;
    endcase
  end

endmodule

// ===== design/pce_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_datapath
// Running sums, shared 32x32 long multiplier, restoring divider and root.
// ----------------------------------------------------------------------------
module pce_datapath #(
  parameter int MAX_ITEMS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  pce_pkg::sample_t sample,
  input  pce_pkg::cmd_t    cmd,
  output logic             done,
  output pce_pkg::result_t result
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int SX_W = SB + CW;
  localparam int SQ_W = 2 * SB + CW;
  localparam int OW   = pce_pkg::OP_W;
  localparam int MW   = pce_pkg::MUL_W;
  localparam int PW   = pce_pkg::PROD_W;
  localparam int HW   = MW / 2;

  // accumulation
  logic [CW-1:0]          count;
  logic signed [SX_W-1:0] sum_x, sum_y;
  logic signed [SQ_W-1:0] sum_xx, sum_yy, sum_xy;
  logic                   ovf;
  logic signed [SB-1:0]   xs, ys;
  logic signed [2*SB-1:0] pxx, pyy, pxy;

  assign xs  = sample.sample_x[SB-1:0];
  assign ys  = sample.sample_y[SB-1:0];
  assign pxx = xs * xs;
  assign pyy = ys * ys;
  assign pxy = xs * ys;

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
      sum_xy <= '0;
      ovf    <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count < CW'(MAX_ITEMS)) begin
        count  <= count + 1'b1;
        sum_x  <= sum_x + {{CW{xs[SB-1]}}, xs};
        sum_y  <= sum_y + {{CW{ys[SB-1]}}, ys};
        sum_xx <= sum_xx + {{CW{pxx[2*SB-1]}}, pxx};
        sum_yy <= sum_yy + {{CW{pyy[2*SB-1]}}, pyy};
        sum_xy <= sum_xy + {{CW{pxy[2*SB-1]}}, pxy};
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // finish-phase operands, sign-extended
  logic signed [OW-1:0] n_e, sx_e, sy_e, sxx_e, syy_e, sxy_e;
  logic signed [OW-1:0] tmp, da, db, num;
  logic [PW-1:0]        msq, den;

  assign n_e   = {{(OW-CW){1'b0}}, count};
  assign sx_e  = {{(OW-SX_W){sum_x[SX_W-1]}}, sum_x};
  assign sy_e  = {{(OW-SX_W){sum_y[SX_W-1]}}, sum_y};
  assign sxx_e = {{(OW-SQ_W){sum_xx[SQ_W-1]}}, sum_xx};
  assign syy_e = {{(OW-SQ_W){sum_yy[SQ_W-1]}}, sum_yy};
  assign sxy_e = {{(OW-SQ_W){sum_xy[SQ_W-1]}}, sum_xy};

  logic signed [OW-1:0] sel_a, sel_b, num_abs;
  logic [OW-1:0]        abs_a, abs_b;

  assign num_abs = num[OW-1] ? -num : num;

  always_comb begin
    case (cmd.mul_op)
      pce_pkg::OP_N_SXX:  begin sel_a = n_e;     sel_b = sxx_e;   end
      pce_pkg::OP_SX_SX:  begin sel_a = sx_e;    sel_b = sx_e;    end
      pce_pkg::OP_N_SYY:  begin sel_a = n_e;     sel_b = syy_e;   end
      pce_pkg::OP_SY_SY:  begin sel_a = sy_e;    sel_b = sy_e;    end
      pce_pkg::OP_N_SXY:  begin sel_a = n_e;     sel_b = sxy_e;   end
      pce_pkg::OP_SX_SY:  begin sel_a = sx_e;    sel_b = sy_e;    end
      pce_pkg::OP_MAG_SQ: begin sel_a = num_abs; sel_b = num_abs; end
      pce_pkg::OP_DEN:    begin sel_a = da;      sel_b = db;      end
      default:            begin sel_a = '0;      sel_b = '0;      end
    endcase
    abs_a = sel_a[OW-1] ? -sel_a : sel_a;
    abs_b = sel_b[OW-1] ? -sel_b : sel_b;
  end

  // long multiply: four 32x32 partial products
  logic [MW-1:0]   opa, opb;
  logic            pneg;
  logic [PW-1:0]   acc;
  logic [HW-1:0]   part_a, part_b;
  logic [MW-1:0]   pp;
  logic [PW-1:0]   pp_sh;
  logic [PW:0]     prod_s;
  logic signed [OW-1:0] prod;

  assign part_a = cmd.mul_step[1] ? opa[MW-1:HW] : opa[HW-1:0];
  assign part_b = cmd.mul_step[0] ? opb[MW-1:HW] : opb[HW-1:0];
  assign pp     = part_a * part_b;

  always_comb begin
    case ({1'b0, cmd.mul_step[1]} + {1'b0, cmd.mul_step[0]})
      2'd0:    pp_sh = {{(PW-MW){1'b0}}, pp};
      2'd1:    pp_sh = {{(PW-MW-HW){1'b0}}, pp, {HW{1'b0}}};
      default: pp_sh = {pp, {MW{1'b0}}};
    endcase
  end

  assign prod_s = pneg ? -{1'b0, acc} : {1'b0, acc};
  assign prod   = prod_s[OW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      opa  <= abs_a[MW-1:0];
      opb  <= abs_b[MW-1:0];
      pneg <= sel_a[OW-1] ^ sel_b[OW-1];
      acc  <= '0;
    end else if (cmd.mul_run) begin
      acc <= acc + pp_sh;
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        pce_pkg::OP_SX_SX:  da  <= tmp - prod;
        pce_pkg::OP_SY_SY:  db  <= tmp - prod;
        pce_pkg::OP_SX_SY:  num <= tmp - prod;
        pce_pkg::OP_MAG_SQ: msq <= acc;
        pce_pkg::OP_DEN:    den <= acc;
        default:            tmp <= prod;
      endcase
    end
  end

  // restoring divide: quo = floor(msq * 2^32 / den)
  logic [PW-1:0]             rem;
  logic [pce_pkg::QUO_W-1:0] quo;
  logic [PW:0]               rem2, rem_sub;
  logic                      ge;

  assign rem2    = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, den};
  assign ge      = (rem2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      if (msq >= den) begin
        rem <= msq - den;
        quo <= {{(pce_pkg::QUO_W-1){1'b0}}, 1'b1};
      end else begin
        rem <= msq;
        quo <= '0;
      end
    end else if (cmd.div_run) begin
      rem <= ge ? rem_sub[PW-1:0] : rem2[PW-1:0];
      quo <= {quo[pce_pkg::QUO_W-2:0], ge};
    end
  end

  // bitwise integer square root of the quotient
  logic [pce_pkg::ROOT_W-1:0]   root, trial;
  logic [2*pce_pkg::ROOT_W-1:0] trial_sq;

  assign trial    = root | (pce_pkg::ROOT_W'(1) << cmd.root_bit);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      root <= '0;
    end else if (cmd.sqrt_run) begin
      if (trial_sq <= {{(2*pce_pkg::ROOT_W-pce_pkg::QUO_W){1'b0}}, quo}) root <= trial;
    end
  end

  // result word
  logic [pce_pkg::ROOT_W:0] q;
  logic [pce_pkg::ROOT_W:0] q_neg;
  logic                     degen;
  logic signed [15:0]       corr;
  logic [31:0]              cnt_ext;

  assign q       = ({1'b0, root} + 1'b1) >> 1;
  assign q_neg   = -q;
  assign degen   = (da[OW-1] || da == '0) || (db[OW-1] || db == '0);
  assign cnt_ext = 32'(count);

  always_comb begin
    if (degen || ovf) corr = '0;
    else if (num[OW-1]) corr = q_neg[15:0];
    else if (q > 18'd32767) corr = 16'sd32767;
    else corr = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      result.correlation <= corr;
      result.degenerate  <= degen;
      result.too_many    <= ovf;
      result.item_count  <= cnt_ext[12:0];
    end
  end

endmodule

// ===== design/pearson_correlation_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_engine_core
// Running-sum Pearson correlation over paired samples, Q1.15 result.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while a set accumulates (busy stays low)
// finish: the last word of a set starts a busy finish pass (eight long
//   multiplies through one 32x32 unit, a 33-step divide, a 17-step root and
//   an emit state); the result strobe follows in the next cycle
// reset: synchronous, clears counts, sums and flags; results cannot be stalled
module pearson_correlation_engine_core #(
  parameter int MAX_ITEMS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pce_pkg::sample_t sample,
  output logic             done,
  output pce_pkg::result_t result
);

  pce_pkg::cmd_t cmd;

  pce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (sample.last),
    .busy  (busy),
    .cmd   (cmd)
  );

  pce_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

endmodule

// ===== tb/pearson_correlation_engine_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_engine_core_checker
// Watches the sample and result channels of the correlation engine. It keeps
// its own running sums, works out the expected Q1.15 coefficient and flags
// for every set, and compares each result word with the oldest one expected.
// ----------------------------------------------------------------------------
module pearson_correlation_engine_core_checker #(
  parameter int MAX_ITEMS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  pce_pkg::sample_t sample,
  input  logic             done,
  input  pce_pkg::result_t result,
  output int               errors,
  output int               pending
);

  int unsigned      n_pairs;
  longint           acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  bit               overflowed;
  pce_pkg::result_t coeff_q[$];

  function automatic longint sext(logic [15:0] raw);
    logic [15:0] v;
    v = raw & 16'((17'd1 << SAMPLE_BITS) - 17'd1);
    if (v[SAMPLE_BITS-1]) return longint'(v) - (longint'(1) << SAMPLE_BITS);
    return longint'(v);
  endfunction

  // largest q with (2q-1)^2 * da * db <= (65536 * mag)^2
  function automatic logic [15:0] q15_coeff(longint unsigned mag, bit neg,
                                            longint unsigned da,
                                            longint unsigned db);
    logic [191:0] den, rhs, lhs, odd;
    int unsigned lo, hi, mid;
    int q;
    den = {128'd0, da} * {128'd0, db};
    rhs = {128'd0, mag} << 16;
    rhs = rhs * rhs;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 192'(2 * mid - 1);
      lhs = odd * odd * den;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    q = lo;
    if (neg) q = -q;
    else if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  task automatic take_pair(pce_pkg::sample_t s);
    longint x, y, n, da, db, num;
    pce_pkg::result_t r;
    x = sext(s.sample_x);
    y = sext(s.sample_y);
    if (n_pairs < MAX_ITEMS) begin
      n_pairs++;
      acc_x  += x;
      acc_y  += y;
      acc_xx += x * x;
      acc_yy += y * y;
      acc_xy += x * y;
    end else begin
      overflowed = 1;
    end
    if (!s.last) return;
    n   = n_pairs;
    da  = n * acc_xx - acc_x * acc_x;
    db  = n * acc_yy - acc_y * acc_y;
    num = n * acc_xy - acc_x * acc_y;
    r.degenerate  = (da <= 0) || (db <= 0);
    r.too_many    = overflowed;
    r.item_count  = n_pairs[12:0];
    r.correlation = '0;
    if (!r.degenerate && !overflowed)
      r.correlation = q15_coeff(num < 0 ? -num : num, num < 0, da, db);
    coeff_q.push_back(r);
    n_pairs = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    overflowed = 0;
  endtask

  assign pending = coeff_q.size();

  initial begin
    errors = 0;
    n_pairs = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    overflowed = 0;
  end

  always @(posedge clk) begin
    pce_pkg::result_t want;
    if (!rst) begin
      if (done) begin
        if (coeff_q.size() == 0) begin
          $display("%0t: result word with none expected: got %p", $time, result);
          errors++;
        end else begin
          want = coeff_q.pop_front();
          if (result !== want) begin
            $display("%0t: result mismatch: expected %p, got %p", $time, want, result);
            errors++;
          end
        end
      end
      if (start && !busy) take_pair(sample);
    end
  end
endmodule

// ===== tb/pearson_correlation_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_engine_core_tb
// Drives sample sets into the correlation engine: directed extremes (perfect
// and inverse correlation, single pairs, zero variance) and then random sets
// of mixed shapes with random gaps, gap-free for one stretch; a checker compares.
// ----------------------------------------------------------------------------
module pearson_correlation_engine_core_tb;

  logic             clk = 0;
  logic             rst = 1;
  logic             start = 0;
  logic             busy;
  pce_pkg::sample_t sample = '0;
  logic             done;
  pce_pkg::result_t result;
  int               errors, pending;
  bit               gaps_on = 1;

  always #4 clk = ~clk;

  pearson_correlation_engine_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample(sample), .done(done), .result(result)
  );

  pearson_correlation_engine_core_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  // hold one word on the port until it is taken
  task automatic send_word(logic [15:0] x, logic [15:0] y, logic last);
    while (gaps_on && $urandom_range(99) < 23) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    sample <= '{sample_x: x, sample_y: y, last: last};
    do @(posedge clk); while (busy);
  endtask

  task automatic random_set(int len);
    int mode;
    logic [15:0] x, y, base;
    mode = $urandom_range(5);
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      x = 16'($urandom);
      case (mode)
        0: y = 16'($urandom);
        1: y = x + 16'($urandom_range(0, 64)) - 16'd32;   // strong positive
        2: y = -x + 16'($urandom_range(0, 16));            // strong negative
        3: begin
          x = base + 16'($urandom_range(7));
          y = 16'($urandom_range(15)) - 16'd8;
        end
        4: y = base;                                       // y has no variance
        default: y = (i % 2) ? 16'h7fff : 16'h8000;
      endcase
      send_word(x, y, i == len - 1);
    end
  endtask

  initial begin
    int sent, len;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // perfect and inverse correlation at full scale
    send_word(16'h7fff, 16'h7fff, 0);
    send_word(16'h8000, 16'h8000, 1);
    send_word(16'h7fff, 16'h8000, 0);
    send_word(16'h8000, 16'h7fff, 1);
    send_word(16'h0001, 16'hffff, 0);
    send_word(16'h0000, 16'h0000, 0);
    send_word(16'hffff, 16'h0001, 1);
    // single pair, zero variance on either side
    send_word(16'h1234, 16'h8000, 1);
    send_word(16'h0005, 16'h0001, 0);
    send_word(16'h0005, 16'h0002, 1);
    send_word(16'h0001, 16'h7777, 0);
    send_word(16'h0002, 16'h7777, 1);
    send_word(16'h0000, 16'h0000, 0);
    send_word(16'h0000, 16'h0000, 1);
    sent = 0;
    while (sent < 1900) begin
      gaps_on = !(sent > 600 && sent < 900);
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = $urandom_range(50, 200);
        default: len = $urandom_range(2, 20);
      endcase
      random_set(len);
      sent += len;
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
design/pce_pkg.sv
design/pce_ctrl.sv
design/pce_datapath.sv
design/pearson_correlation_engine_core.sv
tb/pearson_correlation_engine_core_checker.sv
tb/pearson_correlation_engine_core_tb.sv
